/* rtl/xo256ss_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package xo256ss_pkg;

  localparam int WORD_W = 64;
  localparam int HALF_W = WORD_W / 2;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [HALF_W-1:0] half_t;

  // Request into the shared multiplier; operands are sampled on start.
  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mul_req_t;

  typedef struct packed {
    logic  done;
    word_t prod;
  } mul_rsp_t;

  localparam logic MODE_NEXT = 1'b0;
  localparam logic MODE_SEED = 1'b1;

  localparam word_t MIX_START  = 64'h243F6A8885A308D3;
  localparam word_t GOLDEN_INC = 64'h9E3779B97F4A7C15;
  localparam word_t SM_MUL_A   = 64'hBF58476D1CE4E5B9;
  localparam word_t SM_MUL_B   = 64'h94D049BB133111EB;
  localparam word_t FALLBACK_0 = 64'h9E3779B97F4A7C15;
  localparam word_t FALLBACK_1 = 64'hD1B54A32D192ED03;
  localparam word_t FALLBACK_2 = 64'h85E1C3D753D46D27;
  localparam word_t FALLBACK_3 = 64'h94D049BB133111EB;

  localparam int ROT_OUT   = 7;
  localparam int ROT_STATE = 45;
  localparam int SHL_T     = 17;

  function automatic word_t rotl(input word_t v, input int k);
    rotl = (v << k) | (v >> (WORD_W - k));
  endfunction

endpackage

`default_nettype wire

/* rtl/xo256ss_if.sv */
`timescale 1ns / 1ps
`default_nettype none

interface xo256ss_in_if import xo256ss_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  mode;
  word_t entropy_word_0;
  word_t entropy_word_1;
  word_t entropy_word_2;
  word_t entropy_word_3;

  modport source (
    output valid, mode, entropy_word_0, entropy_word_1, entropy_word_2, entropy_word_3,
    input  ready
  );
  modport sink (
    input  valid, mode, entropy_word_0, entropy_word_1, entropy_word_2, entropy_word_3,
    output ready
  );
endinterface

interface xo256ss_out_if import xo256ss_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t random_word;

  modport source (output valid, random_word, input ready);
  modport sink (input valid, random_word, output ready);
endinterface

`default_nettype wire

/* rtl/xoshiro256ss_prng_with_seeding_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// xoshiro256** generator with SplitMix64 seeding.
// req carries mode and four entropy words. mode = 0 asks for the next random
// word; mode = 1 reseeds the 256-bit state from the entropy words and gives no
// result. rsp carries random_word, held in an output register until taken.
// Next item: the state advance is registered at the transfer on req; the output
// scramble follows in S_NXT, which holds until the output register is free. req
// is ready again as the result enters the output register, and not before.
// Seed item: each entropy word goes through a mixing step and then two 64-bit
// products in turn on the one shared 32x32 multiplier, and a final all-zero
// check follows the fourth word; req is ready again only after that check.
// Reset loads the four fallback constants into the state and clears rsp.valid.
// If rsp stalls, a finished word waits in the output register; a further next
// item is taken but holds in its finish cycle until the register frees up.
// Seed items run on while a word waits.
module xoshiro256ss_prng_with_seeding_unit import xo256ss_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  xo256ss_in_if.sink    req,
  xo256ss_out_if.source rsp
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NXT  = 3'd1;
  localparam logic [2:0] S_MIX  = 3'd2;
  localparam logic [2:0] S_MULA = 3'd3;
  localparam logic [2:0] S_MULB = 3'd4;
  localparam logic [2:0] S_CHK  = 3'd5;

  logic [2:0] state;
  word_t      st [4];
  word_t      ent [4];
  word_t      mixer;
  word_t      p5;
  logic [1:0] idx;
  logic       nz;
  logic       out_valid;
  word_t      out_word;
  logic       out_free;

  mul_req_t   mreq;
  mul_rsp_t   mrsp;

  word_t      mix_new;
  word_t      z1;
  word_t      z2;
  word_t      z3;
  word_t      t17;
  word_t      n0;
  word_t      n1;
  word_t      n2;
  word_t      n3;
  word_t      rw;
  word_t      rw9;

  xo256ss_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  always_comb begin
    mix_new = (mixer ^ ent[0]) + GOLDEN_INC;
    z1      = mix_new ^ (mix_new >> 30);
    z2      = mrsp.prod ^ (mrsp.prod >> 27);
    z3      = mrsp.prod ^ (mrsp.prod >> 31);

    mreq.start = (state == S_MIX) || ((state == S_MULA) && mrsp.done);
    mreq.a     = (state == S_MIX) ? z1 : z2;
    mreq.b     = (state == S_MIX) ? SM_MUL_A : SM_MUL_B;

    // xoshiro256 state advance
    t17 = st[1] << SHL_T;
    n2  = st[2] ^ st[0];
    n3  = st[3] ^ st[1];
    n1  = st[1] ^ n2;
    n0  = st[0] ^ n3;

    rw  = rotl(p5, ROT_OUT);
    rw9 = rw + (rw << 3);

    out_free = !out_valid || rsp.ready;
  end

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.random_word = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      st[0]     <= FALLBACK_0;
      st[1]     <= FALLBACK_1;
      st[2]     <= FALLBACK_2;
      st[3]     <= FALLBACK_3;
    end else begin
      // in the finish cycle the case below owns the output register
      if (out_valid && rsp.ready && (state != S_NXT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            if (req.mode == MODE_SEED) begin
              ent[0] <= req.entropy_word_0;
              ent[1] <= req.entropy_word_1;
              ent[2] <= req.entropy_word_2;
              ent[3] <= req.entropy_word_3;
              mixer  <= MIX_START;
              idx    <= 2'd0;
              nz     <= 1'b0;
              state  <= S_MIX;
            end else begin
              p5    <= st[1] + (st[1] << 2);
              st[0] <= n0;
              st[1] <= n1;
              st[2] <= n2 ^ t17;
              st[3] <= rotl(n3, ROT_STATE);
              state <= S_NXT;
            end
          end
        end
        S_NXT: begin
          // hold until the output register frees up
          if (out_free) begin
            out_word  <= rw9;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_MIX: begin
          mixer <= mix_new;
          state <= S_MULA;
        end
        S_MULA: begin
          if (mrsp.done) begin
            state <= S_MULB;
          end
        end
        S_MULB: begin
          if (mrsp.done) begin
            st[idx] <= z3;
            nz      <= nz | (|z3);
            ent[0]  <= ent[1];
            ent[1]  <= ent[2];
            ent[2]  <= ent[3];
            idx     <= idx + 2'd1;
            state   <= (idx == 2'd3) ? S_CHK : S_MIX;
          end
        end
        S_CHK: begin
          if (!nz) begin
            st[0] <= FALLBACK_0;
            st[1] <= FALLBACK_1;
            st[2] <= FALLBACK_2;
            st[3] <= FALLBACK_3;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_mul_done_in_seed: assert property (@(posedge clk) disable iff (rst)
    mrsp.done |-> (state == S_MULA || state == S_MULB))
    else $error("multiplier finished outside a seeding step");

  a_out_from_next: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_NXT)
    else $error("result appeared without a next item");

  a_state_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((st[0] | st[1] | st[2] | st[3]) != '0))
    else $error("generator state is all zero while idle");

endmodule

`default_nettype wire

/* rtl/xo256ss_mul.sv */
`timescale 1ns / 1ps
`default_nettype none

// 64x64 -> low 64 bits, one 32x32 partial product per cycle.
module xo256ss_mul import xo256ss_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  localparam logic [1:0] LAST_STEP = 2'd2;

  word_t      a;
  word_t      b;
  word_t      acc;
  logic [1:0] step;
  logic       busy;
  logic       done;
  half_t      op_x;
  half_t      op_y;
  word_t      pp;

  always_comb begin
    case (step)
      2'd0: begin
        op_x = a[HALF_W-1:0];
        op_y = b[HALF_W-1:0];
      end
      2'd1: begin
        op_x = a[HALF_W-1:0];
        op_y = b[WORD_W-1:HALF_W];
      end
      default: begin
        op_x = a[WORD_W-1:HALF_W];
        op_y = b[HALF_W-1:0];
      end
    endcase
    pp = {{HALF_W{1'b0}}, op_x} * {{HALF_W{1'b0}}, op_y};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        a    <= req.a;
        b    <= req.b;
        step <= 2'd0;
        busy <= 1'b1;
      end else if (busy) begin
        if (step == 2'd0) begin
          acc <= pp;
        end else begin
          // cross terms only reach the upper half
          acc <= {acc[WORD_W-1:HALF_W] + pp[HALF_W-1:0], acc[HALF_W-1:0]};
        end
        if (step == LAST_STEP) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 2'd1;
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = acc;

endmodule

`default_nettype wire

/* test/xoshiro256ss_prng_with_seeding_unit_checker.sv */
`timescale 1ns / 1ps

module xoshiro256ss_prng_with_seeding_unit_checker import xo256ss_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  xo256ss_in_if  req,
  xo256ss_out_if rsp,
  output int     mismatches,
  output int     outstanding
);

  localparam int MAX_PRINTS = 40;

  word_t gen_st [4];
  word_t pending_words [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic word_t rot_up(input word_t v, input int k);
    return (v << k) | (v >> (WORD_W - k));
  endfunction

  function automatic word_t splitmix_out(input word_t m);
    word_t z;
    z = (m ^ (m >> 30)) * SM_MUL_A;
    z = (z ^ (z >> 27)) * SM_MUL_B;
    return z ^ (z >> 31);
  endfunction

  task automatic load_fallback_state();
    gen_st[0] = FALLBACK_0;
    gen_st[1] = FALLBACK_1;
    gen_st[2] = FALLBACK_2;
    gen_st[3] = FALLBACK_3;
  endtask

  task automatic seed_generator(input word_t e0, input word_t e1, input word_t e2,
                                input word_t e3);
    word_t words [4];
    word_t mixer;
    words = '{e0, e1, e2, e3};
    mixer = MIX_START;
    for (int i = 0; i < 4; i++) begin
      mixer = (mixer ^ words[i]) + GOLDEN_INC;
      gen_st[i] = splitmix_out(mixer);
    end
    // an all-zero state would lock the generator
    if ((gen_st[0] | gen_st[1] | gen_st[2] | gen_st[3]) == '0) begin
      load_fallback_state();
    end
  endtask

  task automatic draw_word(output word_t w);
    word_t t;
    w = rot_up(gen_st[1] * word_t'(5), ROT_OUT) * word_t'(9);
    t = gen_st[1] << SHL_T;
    gen_st[2] ^= gen_st[0];
    gen_st[3] ^= gen_st[1];
    gen_st[1] ^= gen_st[2];
    gen_st[0] ^= gen_st[3];
    gen_st[2] ^= t;
    gen_st[3] = rot_up(gen_st[3], ROT_STATE);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) begin
      $display("[%0t] MISMATCH: %s", $time, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk) begin : watch
    word_t want;
    word_t drawn;
    if (rst) begin
      load_fallback_state();
      pending_words.delete();
      outstanding <= 0;
    end else begin
      // retire the response first: it can never belong to a same-edge request
      if (rsp.valid && rsp.ready) begin
        if (pending_words.size() == 0) begin
          report_mismatch($sformatf("random_word %h with nothing expected",
                                    rsp.random_word));
        end else begin
          want = pending_words.pop_front();
          if (rsp.random_word !== want) begin
            report_mismatch($sformatf("random_word got %h want %h",
                                      rsp.random_word, want));
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.mode == MODE_SEED) begin
          seed_generator(req.entropy_word_0, req.entropy_word_1,
                         req.entropy_word_2, req.entropy_word_3);
        end else begin
          draw_word(drawn);
          pending_words.push_back(drawn);
        end
      end
      outstanding <= pending_words.size();
    end
  end

endmodule

/* test/xoshiro256ss_prng_with_seeding_unit_tb.sv */
`timescale 1ns / 1ps

module xoshiro256ss_prng_with_seeding_unit_tb;
  import xo256ss_pkg::*;

  localparam int RANDOM_ITEMS = 600;
  localparam int QUIET_ITEMS  = 100;
  localparam int LONG_HOLD    = 80;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 200000;

  // entropy that drives every SplitMix64 mixer to zero, so each state word is zero
  localparam word_t NEG_INC = word_t'(0) - GOLDEN_INC;
  localparam word_t ZERO_W0 = MIX_START ^ NEG_INC;
  localparam word_t ALT_A   = 64'hAAAAAAAAAAAAAAAA;
  localparam word_t ALT_5   = 64'h5555555555555555;

  logic clk = 1'b0;
  logic rst = 1'b1;
  bit   quiet_tail = 1'b0;
  bit   long_hold_req = 1'b0;
  int   mismatches;
  int   outstanding;
  int   cycle_cnt = 0;

  xo256ss_in_if  req_if ();
  xo256ss_out_if rsp_if ();

  xoshiro256ss_prng_with_seeding_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  xoshiro256ss_prng_with_seeding_unit_checker mon (
    .clk         (clk),
    .rst         (rst),
    .req         (req_if),
    .rsp         (rsp_if),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic word_t rand_word();
    return {$urandom, $urandom};
  endfunction

  // hold the item until the transfer edge
  task automatic send_item(input logic m, input word_t e0, input word_t e1,
                           input word_t e2, input word_t e3);
    req_if.valid          <= 1'b1;
    req_if.mode           <= m;
    req_if.entropy_word_0 <= e0;
    req_if.entropy_word_1 <= e1;
    req_if.entropy_word_2 <= e2;
    req_if.entropy_word_3 <= e3;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic pause_sender(input int n);
    req_if.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic send_random_item();
    word_t e [4];
    int    pick;
    for (int i = 0; i < 4; i++) e[i] = rand_word();
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      send_item(MODE_SEED, ZERO_W0, NEG_INC, NEG_INC, NEG_INC);
    end else if (pick < 5) begin
      // zero out one state word only
      send_item(MODE_SEED, ZERO_W0, e[1], e[2], e[3]);
    end else if (pick < 14) begin
      send_item(MODE_SEED, e[0], e[1], e[2], e[3]);
    end else begin
      send_item(MODE_NEXT, e[0], e[1], e[2], e[3]);
    end
  endtask

  initial begin
    req_if.valid          = 1'b0;
    req_if.mode           = MODE_NEXT;
    req_if.entropy_word_0 = '0;
    req_if.entropy_word_1 = '0;
    req_if.entropy_word_2 = '0;
    req_if.entropy_word_3 = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // draw from the reset constants; entropy on a next request is ignored
    send_item(MODE_NEXT, '1, '1, '1, '1);
    send_item(MODE_NEXT, '0, '0, '0, '0);
    send_item(MODE_NEXT, ALT_A, ALT_5, ALT_A, ALT_5);
    send_item(MODE_SEED, '0, '0, '0, '0);
    send_item(MODE_NEXT, '0, '0, '0, '0);
    send_item(MODE_NEXT, '1, '1, '1, '1);
    send_item(MODE_SEED, '1, '1, '1, '1);
    send_item(MODE_NEXT, '0, '0, '0, '0);
    // all-zero seeded state falls back to the reset constants
    send_item(MODE_SEED, ZERO_W0, NEG_INC, NEG_INC, NEG_INC);
    send_item(MODE_NEXT, '0, '0, '0, '0);
    send_item(MODE_NEXT, '0, '0, '0, '0);
    send_item(MODE_SEED, ZERO_W0, rand_word(), rand_word(), rand_word());
    send_item(MODE_NEXT, rand_word(), rand_word(), rand_word(), rand_word());
    send_item(MODE_SEED, ALT_5, ALT_A, ALT_5, ALT_A);
    send_item(MODE_NEXT, '0, '0, '0, '0);
    send_item(MODE_SEED, rand_word(), rand_word(), rand_word(), rand_word());
    send_item(MODE_SEED, rand_word(), rand_word(), rand_word(), rand_word());
    send_item(MODE_NEXT, '0, '0, '0, '0);
    send_item(MODE_NEXT, '1, '1, '1, '1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) long_hold_req = 1'b1;
      if (n == 350) begin
        // drain completely before going on
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
      end
      if (n == RANDOM_ITEMS - QUIET_ITEMS) quiet_tail = 1'b1;
      if (!quiet_tail && (n / 40) % 3 != 2 && $urandom_range(0, 3) == 0) begin
        pause_sender($urandom_range(1, 12));
      end
      send_random_item();
    end

    req_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    rsp_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        // hold off long enough for the block to back up into its input
        long_hold_req = 1'b0;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end else begin
        rsp_if.ready <= 1'b1;
        repeat (quiet_tail ? 1 : $urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
